@@ hw/rtl/esub_pkg.sv @@
package esub_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  event_num;
        logic [15:0] handler_id;
        logic [31:0] context_req;
        logic [31:0] timestamp;
    } esub_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [15:0] handler_out;
        logic [31:0] context_out;
        logic [31:0] time_out;
        logic        last;
    } esub_rsp_t;

    // request modes
    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_UNREG_H  = 2'd1;
    localparam logic [1:0] MODE_UNREG_EV = 2'd2;
    localparam logic [1:0] MODE_DISPATCH = 2'd3;

    // result status codes
    localparam logic [2:0] ST_REGISTERED = 3'd0;
    localparam logic [2:0] ST_PRESENT    = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NULL       = 3'd3;
    localparam logic [2:0] ST_DONE       = 3'd4;

    localparam logic [7:0] EV_EMPTY = 8'h00;
    localparam logic [7:0] EV_ANY   = 8'hFF;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } esub_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic can_step;
        logic last_slot;
        logic out_free;
    } esub_sts_t;

endpackage

@@ hw/rtl/esub_dp.sv @@
module esub_dp #(
    parameter int SLOTS        = 64,
    parameter int HANDLER_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  esub_pkg::esub_cmd_t cmd,
    output esub_pkg::esub_sts_t sts,
    input  esub_pkg::esub_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output esub_pkg::esub_rsp_t m_data
);
    import esub_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HW = HANDLER_BITS;
    localparam int WW = 8 + HW;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [WW-1:0]    mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [WW-1:0]    rd_data_reg;
    logic [IW-1:0]    idx_reg;
    esub_req_t        req_reg;
    logic             hit_reg;
    logic             empty_found_reg;
    logic [IW-1:0]    empty_idx_reg;
    logic             pend_valid_reg;
    logic [HW-1:0]    pend_h_reg;
    logic             out_valid_reg;
    esub_rsp_t        out_reg;

    logic [HW+15:0] h_ext;
    logic [HW+15:0] p_ext;
    logic [HW-1:0]  req_h;
    logic [7:0]     slot_ev;
    logic [HW-1:0]  slot_h;
    logic           ev_hit;
    logic           h_eq;
    logic           clr;
    logic           emit;
    logic           out_free;
    logic           is_last;
    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    logic           wr_en;
    logic           load_out;
    esub_rsp_t      emit_rsp;
    esub_rsp_t      fin_rsp;

    // handler field narrowed or widened to the stored width
    assign h_ext = {{HW{1'b0}}, req_reg.handler_id};
    assign req_h = h_ext[HW-1:0];
    assign p_ext = {16'b0, pend_h_reg};

    // a slot never written since reset or since being cleared reads as empty
    assign slot_ev = valid_reg[idx_reg] ? rd_data_reg[WW-1:HW] : EV_EMPTY;
    assign slot_h  = valid_reg[idx_reg] ? rd_data_reg[HW-1:0] : '0;
    assign ev_hit  = (req_reg.event_num == EV_ANY) || (slot_ev == req_reg.event_num);
    assign h_eq    = (slot_h == req_h);

    always_comb begin
        clr  = 1'b0;
        emit = 1'b0;
        case (req_reg.mode)
            MODE_REGISTER: begin
                clr  = 1'b0;
            end
            MODE_UNREG_H: begin
                clr = (req_h != '0) && h_eq;
            end
            MODE_UNREG_EV: begin
                clr = (req_reg.event_num != EV_EMPTY) && ev_hit;
            end
            MODE_DISPATCH: begin
                emit = ev_hit && (slot_h != '0);
            end
            default: begin
                clr  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    assign out_free      = !out_valid_reg || m_ready;
    assign is_last       = (idx_reg == LAST_IDX);
    assign sts.can_step  = !(emit && pend_valid_reg) || out_free;
    assign sts.last_slot = is_last;
    assign sts.out_free  = out_free;

    assign rd_en   = cmd.load || (cmd.step && !is_last);
    assign rd_addr = cmd.load ? '0 : idx_reg + 1'b1;
    assign wr_en   = cmd.finish && (req_reg.mode == MODE_REGISTER) && (req_h != '0)
                     && !hit_reg && empty_found_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[empty_idx_reg] <= {req_reg.event_num, req_h};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_data;
        end
        if (cmd.step && emit) begin
            pend_h_reg <= slot_h;
        end
        if (load_out) begin
            out_reg <= cmd.finish ? fin_rsp : emit_rsp;
        end
    end

    // held match becomes a non-final result once the next match turns up
    always_comb begin
        emit_rsp.status      = ST_DONE;
        emit_rsp.found       = 1'b1;
        emit_rsp.handler_out = p_ext[15:0];
        emit_rsp.context_out = req_reg.context_req;
        emit_rsp.time_out    = req_reg.timestamp;
        emit_rsp.last        = 1'b0;
    end

    always_comb begin
        fin_rsp.status      = ST_DONE;
        fin_rsp.found       = 1'b0;
        fin_rsp.handler_out = '0;
        fin_rsp.context_out = '0;
        fin_rsp.time_out    = '0;
        fin_rsp.last        = 1'b1;
        case (req_reg.mode)
            MODE_REGISTER: begin
                if (req_h == '0) begin
                    fin_rsp.status = ST_NULL;
                end else if (hit_reg) begin
                    fin_rsp.status = ST_PRESENT;
                end else if (empty_found_reg) begin
                    fin_rsp.status = ST_REGISTERED;
                end else begin
                    fin_rsp.status = ST_FULL;
                end
            end
            MODE_DISPATCH: begin
                if (pend_valid_reg) begin
                    fin_rsp.found       = 1'b1;
                    fin_rsp.handler_out = p_ext[15:0];
                    fin_rsp.context_out = req_reg.context_req;
                    fin_rsp.time_out    = req_reg.timestamp;
                end
            end
            default: begin
                fin_rsp.status = ST_DONE;
            end
        endcase
    end

    assign load_out = (cmd.step && emit && pend_valid_reg) || cmd.finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            idx_reg         <= '0;
            hit_reg         <= 1'b0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg         <= '0;
                hit_reg         <= 1'b0;
                empty_found_reg <= 1'b0;
                pend_valid_reg  <= 1'b0;
            end
            if (cmd.step) begin
                if (!is_last) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (req_reg.mode == MODE_REGISTER) begin
                    if (ev_hit && h_eq) begin
                        hit_reg <= 1'b1;
                    end
                    if ((slot_ev == EV_EMPTY) && !empty_found_reg) begin
                        empty_found_reg <= 1'b1;
                        empty_idx_reg   <= idx_reg;
                    end
                end
                if (clr) begin
                    valid_reg[idx_reg] <= 1'b0;
                end
                if (emit) begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (wr_en) begin
                valid_reg[empty_idx_reg] <= 1'b1;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ hw/rtl/esub_ctrl.sv @@
module esub_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  esub_pkg::esub_sts_t sts,
    output esub_pkg::esub_cmd_t cmd
);
    import esub_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // hold the slot while a dispatch result waits for the output register
                if (sts.can_step) begin
                    cmd.step = 1'b1;
                    if (sts.last_slot) begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/event_subscription_table.sv @@
// event subscription table
// s_ channel takes one request transaction (register, unregister by handler,
// unregister by event, dispatch); m_ channel returns its result transactions.
// register and both unregisters answer with one result; dispatch answers with
// one result per matching slot in slot order, or a single found=0 result,
// and last marks the final result of each request.
// every request walks the whole table through the single read port of the
// slot memory, one slot per cycle while the receiver does not stall; s_ready
// stays low from acceptance until the walk ends and its final result is
// loaded, so a new request is taken only once the last one is finished. a
// dispatch result is held until the next match is seen (or the end of the
// walk), and the last result is registered in the finish state after the
// walk.
// s_ready is high only between requests. when the receiver stalls, the walk
// pauses on the slot that needs to emit a result and resumes once the output
// register drains; nothing is dropped.
// reset (aresetn low, synchronous) marks every slot empty at once through
// per-slot valid bits and drops any result still held; no clearing pass.
module event_subscription_table #(
    parameter int SLOTS        = 64,
    parameter int HANDLER_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  esub_pkg::esub_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output esub_pkg::esub_rsp_t m_data
);
    import esub_pkg::*;

    esub_cmd_t cmd;
    esub_sts_t sts;

    esub_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    esub_dp #(
        .SLOTS        (SLOTS),
        .HANDLER_BITS (HANDLER_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
